// ===== design/ulbd_pkg.sv =====
package ulbd_pkg;

  // Default number of entries in the queue between the front and the back.
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [0:0] {
    CfgEofMode  = 1'b0,
    CfgNullMode = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OpData = 1'b0,
    OpEnd  = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_break;
    logic       code_point_end;
    logic       past_end;
    logic       aborted;
    logic       last;
  } result_t;

  // One queue entry carries the one or two result words caused by one input word.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    second_valid;
  } entry_t;

  typedef struct packed {
    logic eof_mode;
    logic null_mode;
  } cfg_t;

endpackage

// ===== design/ulbd_front.sv =====
module ulbd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ulbd_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  input  ulbd_pkg::item_t  item_i,
  output logic             entry_push_o,
  output ulbd_pkg::entry_t entry_o
);

  localparam logic [7:0] ByteNul  = 8'h00;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteCr   = 8'h0D;
  localparam logic [7:0] ByteC0   = 8'hC0;
  localparam logic [7:0] ByteC2   = 8'hC2;
  localparam logic [7:0] ByteDf   = 8'hDF;
  localparam logic [7:0] ByteE0   = 8'hE0;
  localparam logic [7:0] ByteE2   = 8'hE2;
  localparam logic [7:0] ByteEd   = 8'hED;
  localparam logic [7:0] ByteEf   = 8'hEF;
  localparam logic [7:0] ByteF0   = 8'hF0;
  localparam logic [7:0] ByteF4   = 8'hF4;
  localparam logic [7:0] Byte80   = 8'h80;
  localparam logic [7:0] Byte85   = 8'h85;
  localparam logic [7:0] Byte8f   = 8'h8F;
  localparam logic [7:0] Byte90   = 8'h90;
  localparam logic [7:0] Byte9f   = 8'h9F;
  localparam logic [7:0] ByteA0   = 8'hA0;
  localparam logic [7:0] ByteA8   = 8'hA8;
  localparam logic [7:0] ByteA9   = 8'hA9;
  localparam logic [7:0] ByteBf   = 8'hBF;

  function automatic logic lead2(input logic [7:0] x);
    return (x >= ByteC2) && (x <= ByteDf);
  endfunction

  function automatic logic lead3(input logic [7:0] x);
    return (x >= ByteE0) && (x <= ByteEf);
  endfunction

  function automatic logic lead4(input logic [7:0] x);
    return (x >= ByteF0) && (x <= ByteF4);
  endfunction

  logic [7:0] hist_q [3];
  logic [7:0] hist_d [3];
  logic [7:0] pend_q, pend_d;
  logic       pend_valid_q, pend_valid_d;
  logic       last_break_q, last_break_d;
  logic       halted_q, halted_d;

  logic       is_end;
  logic       is_abort;
  logic [7:0] c, p1, p2, p3, nx;
  logic       has_nx;
  logic       crlf, lb, scope, suffix, range_bad, bad_lead, bad, nonfinal;
  logic       break_after;
  logic       add_past_end;
  ulbd_pkg::result_t pend_res, past_res, abort_res;

  assign is_end   = (item_i.op == ulbd_pkg::OpEnd);
  assign is_abort = !is_end && cfg_i.null_mode && (item_i.byte_value == ByteNul);
  assign c        = pend_q;
  assign p1       = hist_q[0];
  assign p2       = hist_q[1];
  assign p3       = hist_q[2];
  assign has_nx   = !is_end;
  assign nx       = is_end ? 8'h00 : item_i.byte_value;

  // Classification of the pending byte against its three predecessors and its successor.
  always_comb begin
    crlf      = (c == ByteCr) && has_nx && (nx == ByteLf);
    lb        = ((c >= ByteLf) && (c <= ByteCr) && !crlf)
              || ((p1 == ByteC2) && (c == Byte85))
              || ((p2 == ByteE2) && (p1 == Byte80) && ((c == ByteA8) || (c == ByteA9)));
    scope     = lead2(p1) || lead3(p1) || lead3(p2) || lead4(p1) || lead4(p2) || lead4(p3);
    suffix    = (c >= Byte80) && (c <= ByteBf);
    range_bad = ((p1 == ByteE0) && (c >= Byte80) && (c <= Byte9f))
             || ((p1 == ByteEd) && (c >= ByteA0) && (c <= ByteBf))
             || ((p1 == ByteF0) && (c >= Byte80) && (c <= Byte8f))
             || ((p1 == ByteF4) && (c >= Byte90) && (c <= ByteBf));
    bad_lead  = (c >= ByteC0) && !(lead2(c) || lead3(c) || lead4(c));
    bad       = bad_lead || (scope != suffix) || range_bad;
    nonfinal  = ((c >= ByteC0) || lead3(p1) || lead4(p1) || lead4(p2)) && !bad;
    nonfinal  = nonfinal || crlf;
  end

  always_comb begin
    pend_res                = '0;
    pend_res.out_byte       = c;
    pend_res.line_break     = lb;
    pend_res.code_point_end = !nonfinal;

    past_res                = '0;
    past_res.line_break     = 1'b1;
    past_res.code_point_end = 1'b1;
    past_res.past_end       = 1'b1;

    abort_res               = '0;
    abort_res.aborted       = 1'b1;
    abort_res.last          = 1'b1;

    break_after  = pend_valid_q ? lb : last_break_q;
    add_past_end = cfg_i.eof_mode && !break_after;
  end

  always_comb begin
    hist_d       = hist_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    last_break_d = last_break_q;
    halted_d     = halted_q;
    entry_push_o = 1'b0;
    entry_o      = '0;

    if (accept_i) begin
      if (halted_q) begin
        if (is_end) begin
          hist_d       = '{default: '0};
          pend_d       = '0;
          pend_valid_d = 1'b0;
          last_break_d = 1'b1;
          halted_d     = 1'b0;
        end
      end else if (is_end) begin
        if (pend_valid_q) begin
          entry_push_o        = 1'b1;
          entry_o.first       = pend_res;
          entry_o.first.last  = !add_past_end;
          entry_o.second      = past_res;
          entry_o.second.last = 1'b1;
          entry_o.second_valid = add_past_end;
        end else if (add_past_end) begin
          entry_push_o       = 1'b1;
          entry_o.first      = past_res;
          entry_o.first.last = 1'b1;
        end
        hist_d       = '{default: '0};
        pend_d       = '0;
        pend_valid_d = 1'b0;
        last_break_d = 1'b1;
        halted_d     = 1'b0;
      end else begin
        if (pend_valid_q) begin
          hist_d[2]    = p2;
          hist_d[1]    = p1;
          hist_d[0]    = c;
          last_break_d = lb;
        end
        if (is_abort) begin
          entry_push_o = 1'b1;
          if (pend_valid_q) begin
            entry_o.first        = pend_res;
            entry_o.second       = abort_res;
            entry_o.second_valid = 1'b1;
          end else begin
            entry_o.first = abort_res;
          end
          pend_valid_d = 1'b0;
          halted_d     = 1'b1;
        end else begin
          entry_push_o  = pend_valid_q;
          entry_o.first = pend_res;
          pend_d        = item_i.byte_value;
          pend_valid_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q       <= '{default: '0};
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      last_break_q <= 1'b1;
      halted_q     <= 1'b0;
    end else begin
      hist_q       <= hist_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      last_break_q <= last_break_d;
      halted_q     <= halted_d;
    end
  end

endmodule

// ===== design/ulbd_fifo.sv =====
module ulbd_fifo #(
  parameter int unsigned Depth = ulbd_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  ulbd_pkg::entry_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output ulbd_pkg::entry_t rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ulbd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/ulbd_back.sv =====
module ulbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  ulbd_pkg::entry_t  q_data_i,
  output logic              q_pop_o,
  output ulbd_pkg::result_t result_o,
  output logic              empty_o,
  input  logic              pop_i
);

  ulbd_pkg::result_t cur_q, cur_d;
  ulbd_pkg::result_t nxt_q, nxt_d;
  logic              cur_valid_q, cur_valid_d;
  logic              nxt_valid_q, nxt_valid_d;
  logic              taken;

  assign empty_o  = !cur_valid_q;
  assign result_o = cur_q;
  assign taken    = pop_i && cur_valid_q;
  // A new entry loads once the held words are gone or the last one leaves this cycle.
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || (taken && !nxt_valid_q));

  always_comb begin
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    cur_valid_d = cur_valid_q;
    nxt_valid_d = nxt_valid_q;
    if (taken) begin
      cur_d       = nxt_q;
      cur_valid_d = nxt_valid_q;
      nxt_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      cur_d       = q_data_i.first;
      cur_valid_d = 1'b1;
      nxt_d       = q_data_i.second;
      nxt_valid_d = q_data_i.second_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nxt_q <= nxt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      nxt_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      nxt_valid_q <= nxt_valid_d;
    end
  end

endmodule

// ===== design/unicode_line_break_detector_unit.sv =====
// A byte's result word enters the queue when its successor (or the end marker) is accepted,
// then the back end's output register; each byte is held back one word for lookahead.
// Throughput: one input word per cycle while the queue is not full, one result word per cycle while
// results wait and pop is high; a two-result word holds the output stage until both are taken.
// Reset (asynchronous, active low) clears stream state, both mode registers and the queue.
module unicode_line_break_detector_unit #(
  parameter int unsigned QueueDepth = ulbd_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ulbd_pkg::item_t     item_i,
  output logic                empty,
  input  logic                pop,
  output ulbd_pkg::result_t   result_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ulbd_pkg::cfg_idx_e  cfg_index_i,
  input  logic                cfg_data_i
);

  ulbd_pkg::cfg_t   cfg_q;
  ulbd_pkg::entry_t front_entry;
  ulbd_pkg::entry_t q_data;
  logic             front_push;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        ulbd_pkg::CfgEofMode:  cfg_q.eof_mode  <= cfg_data_i;
        ulbd_pkg::CfgNullMode: cfg_q.null_mode <= cfg_data_i;
        default:               cfg_q           <= cfg_q;
      endcase
    end
  end

  ulbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .item_i       (item_i),
    .entry_push_o (front_push),
    .entry_o      (front_entry)
  );

  ulbd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_push),
    .wr_data_i (front_entry),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .rd_data_o (q_data),
    .empty_o   (q_empty)
  );

  ulbd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .result_o  (result_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

// ===== design/ulbd_checker.sv =====
module ulbd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input ulbd_pkg::result_t result_o
);

  // The output stage is emptied by reset.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // A waiting word that is not taken stays unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result word changed or vanished");

  // An abort word always closes the stream and marks nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.aborted) |->
      (result_o.last && !result_o.line_break && !result_o.code_point_end
       && !result_o.past_end && (result_o.out_byte == 8'h00)))
    else $error("malformed abort word");

  // The past-end word is a break with no byte and always ends the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.past_end) |->
      (result_o.line_break && result_o.code_point_end && result_o.last
       && !result_o.aborted && (result_o.out_byte == 8'h00)))
    else $error("malformed past-end word");

endmodule

bind unicode_line_break_detector_unit ulbd_checker u_ulbd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
